@@ sv/sts_pkg.sv @@
// Shared definitions for the sorted table first-match search block.
// Transaction structs, mode and register codes, sequencer states.
// No dependencies.
package sts_pkg;

  localparam int DEPTH_DEFAULT     = 1024;
  localparam int KEY_WIDTH_DEFAULT = 32;

  localparam int IDX_W    = 10;
  localparam int KEY_IN_W = 32;
  localparam int CNT_W    = 11;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef struct packed {
    logic                mode;
    logic [IDX_W-1:0]    entry_index;
    logic [KEY_IN_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_FINISH
  } seq_state_t;

endpackage

@@ sv/sts_cfg.sv @@
// Configuration register file: entries_in_use behind an APB-style port.
// Depends on sts_pkg.
module sts_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sts_pkg::PADDR_W-1:0]   paddr,
  input  logic [sts_pkg::PDATA_W-1:0]   pwdata,
  output logic [sts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [sts_pkg::CNT_W-1:0]     entries_in_use
);

  logic [sts_pkg::CNT_W-1:0] entries_r;
  logic [sts_pkg::CNT_W-1:0] entries_nxt;
  logic                      sel_entries;

  assign sel_entries = (paddr[2] == sts_pkg::REG_ENTRIES_IN_USE);
  assign pready      = 1'b1;

  always_comb begin
    entries_nxt = entries_r;
    if (psel && penable && pwrite && pready && sel_entries) begin
      entries_nxt = pwdata[sts_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  assign prdata = sel_entries ? sts_pkg::PDATA_W'(entries_r) : '0;
  assign entries_in_use = entries_r;

endmodule

@@ sv/sts_key_mem.sv @@
// Key store: single-port-write, single-port-read synchronous memory.
// Read data registered. Depends on sts_pkg.
module sts_key_mem #(
  parameter int DEPTH     = sts_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = sts_pkg::KEY_WIDTH_DEFAULT,
  parameter int AW        = $clog2(sts_pkg::DEPTH_DEFAULT)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [KEY_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [KEY_WIDTH-1:0] rd_data
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/sts_seq.sv @@
// Search sequencer: binary search probes, walk back over duplicates,
// result register towards the output channel. Depends on sts_pkg.
module sts_seq #(
  parameter int DEPTH     = sts_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = sts_pkg::KEY_WIDTH_DEFAULT,
  parameter int AW        = $clog2(sts_pkg::DEPTH_DEFAULT),
  parameter int CW        = $clog2(sts_pkg::DEPTH_DEFAULT) + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      lookup_go,
  input  logic [KEY_WIDTH-1:0]      lookup_key,
  input  logic [sts_pkg::CNT_W-1:0] entries_in_use,
  output logic [AW-1:0]             rd_addr,
  input  logic [KEY_WIDTH-1:0]      rd_data,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sts_pkg::out_item_t        out_data
);

  sts_pkg::seq_state_t state_r, state_nxt;

  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        end_r, end_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sts_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [31:0]          ent_ext;
  logic [CW-1:0]        n_cw;
  logic [AW-1:0]        n_mid;
  logic                 hit;
  logic                 less;
  logic [CW-1:0]        lo_step;
  logic [CW-1:0]        end_step;
  logic [CW-1:0]        mid_step;
  logic                 more;
  logic [AW-1:0]        mid_dec;
  logic                 out_free;

  // shared datapath terms
  always_comb begin
    ent_ext  = 32'(entries_in_use);
    n_cw     = (ent_ext > 32'(DEPTH)) ? CW'(DEPTH) : CW'(ent_ext);
    n_mid    = AW'((n_cw - CW'(1)) >> 1);
    hit      = (rd_data == key_r);
    less     = (key_r < rd_data);
    lo_step  = less ? lo_r : (CW'(mid_r) + CW'(1));
    end_step = less ? CW'(mid_r) : end_r;
    more     = (lo_step < end_step);
    mid_step = lo_step + ((end_step - CW'(1) - lo_step) >> 1);
    mid_dec  = mid_r - AW'(1);
    out_free = !out_valid_r || !out_stall;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sts_pkg::ST_IDLE: begin
        if (lookup_go) begin
          state_nxt = (n_cw == '0) ? sts_pkg::ST_FINISH : sts_pkg::ST_SEARCH;
        end
      end
      sts_pkg::ST_SEARCH: begin
        if (hit) begin
          state_nxt = (mid_r == '0) ? sts_pkg::ST_FINISH : sts_pkg::ST_WALK;
        end else begin
          state_nxt = more ? sts_pkg::ST_SEARCH : sts_pkg::ST_FINISH;
        end
      end
      sts_pkg::ST_WALK: begin
        state_nxt = (hit && (mid_dec != '0)) ? sts_pkg::ST_WALK : sts_pkg::ST_FINISH;
      end
      sts_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = sts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sts_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    lo_nxt       = lo_r;
    end_nxt      = end_r;
    mid_nxt      = mid_r;
    key_nxt      = key_r;
    found_nxt    = found_r;
    rd_addr      = mid_r;
    out_data_nxt = out_data_r;
    unique case (state_r)
      sts_pkg::ST_IDLE: begin
        rd_addr = n_mid;
        if (lookup_go) begin
          lo_nxt    = '0;
          end_nxt   = n_cw;
          mid_nxt   = n_mid;
          key_nxt   = lookup_key;
          found_nxt = 1'b0;
        end
      end
      sts_pkg::ST_SEARCH: begin
        if (hit) begin
          found_nxt = 1'b1;
          rd_addr   = mid_dec;
        end else begin
          lo_nxt  = lo_step;
          end_nxt = end_step;
          mid_nxt = AW'(mid_step);
          rd_addr = AW'(mid_step);
        end
      end
      sts_pkg::ST_WALK: begin
        rd_addr = mid_dec - AW'(1);
        if (hit) begin
          mid_nxt = mid_dec;
        end
      end
      sts_pkg::ST_FINISH: begin
        if (out_free) begin
          out_data_nxt.found       = found_r;
          out_data_nxt.first_index = found_r ? sts_pkg::IDX_W'(mid_r) : '0;
        end
      end
      default: begin
        rd_addr = mid_r;
      end
    endcase
    if ((state_r == sts_pkg::ST_FINISH) && out_free) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sts_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    end_r      <= end_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != sts_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/sorted_table_first_match_search_top.sv @@
// Top level of the sorted table first-match search block.
// Instantiates sts_cfg, sts_key_mem and sts_seq; depends on sts_pkg.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid / in_stall        | in_data  (sts_pkg::in_item_t)
//   out     | output    | out_valid / out_stall      | out_data (sts_pkg::out_item_t)
//   cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A write transaction gives no result.
// A lookup runs P probes (at most ceil(log2(n+1)), n the clamped size), then W walk-back
// reads (equal neighbours below the hit, plus one unless index 0 ends it).
// Reset clears the sequencer, the output valid and entries_in_use; the store is not cleared.
// A finished result waits in the output register while out_stall is high; a write or a
// new lookup is still taken, and a lookup holds its result until the register frees.
module sorted_table_first_match_search_top #(
  parameter int DEPTH     = sts_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = sts_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sts_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sts_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [sts_pkg::PDATA_W-1:0] pwdata,
  output logic [sts_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [sts_pkg::CNT_W-1:0] entries_in_use;
  logic                      in_accept;
  logic                      lookup_go;
  logic                      wr_en;
  logic [KEY_WIDTH-1:0]      key_ext;
  logic [AW-1:0]             rd_addr;
  logic [KEY_WIDTH-1:0]      rd_data;
  logic                      busy;

  assign in_accept = in_valid && !in_stall;
  assign lookup_go = in_accept && (in_data.mode == sts_pkg::MODE_LOOKUP);
  assign wr_en     = in_accept && (in_data.mode == sts_pkg::MODE_WRITE)
                     && (32'(in_data.entry_index) < 32'(DEPTH));
  assign key_ext   = KEY_WIDTH'(in_data.key);
  assign in_stall  = busy;

  sts_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .entries_in_use (entries_in_use)
  );

  sts_key_mem #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (key_ext),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sts_seq #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .lookup_go      (lookup_go),
    .lookup_key     (key_ext),
    .entries_in_use (entries_in_use),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

`ifndef NO_ASSERTIONS
  a_lookup_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_go |=> in_stall)
    else $error("input taken during a lookup");

  a_write_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.mode == sts_pkg::MODE_WRITE)) |=> !in_stall)
    else $error("write transaction did not return to idle");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a lookup in progress");
`endif

endmodule

@@ dv/sorted_table_first_match_search_top_tb.sv @@
// Testbench for sorted_table_first_match_search_top: loads sorted and unsorted keys, sets
// the table size over APB and checks every lookup result against a leftmost binary-search
// predictor. Depends on sts_pkg and the RTL of the block only.
module sorted_table_first_match_search_top_tb;

  localparam int TBL_DEPTH     = sts_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 32;
  localparam int IDLE_LIMIT    = 8000;

  localparam logic [sts_pkg::PADDR_W-1:0] ADDR_ENTRIES  =
    {sts_pkg::REG_ENTRIES_IN_USE, 2'b00};
  localparam logic [sts_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
    {~sts_pkg::REG_ENTRIES_IN_USE, 2'b00};

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  sts_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  sts_pkg::out_item_t          out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sts_pkg::PADDR_W-1:0] paddr;
  logic [sts_pkg::PDATA_W-1:0] pwdata;
  logic [sts_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  logic [sts_pkg::KEY_IN_W-1:0] key_mem [0:TBL_DEPTH-1];
  logic [sts_pkg::CNT_W-1:0]    entries_cfg;
  sts_pkg::out_item_t           lookup_results_q[$];

  int  error_count     = 0;
  int  writes_sent     = 0;
  int  lookups_sent    = 0;
  int  results_checked = 0;
  int  sizes_set       = 0;
  int  idle_cycles     = 0;
  int  stall_left      = 0;
  bit  tx_quiet        = 1'b0;
  bit  rx_quiet        = 1'b0;

  sorted_table_first_match_search_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sts_pkg::out_item_t predict_lookup(logic [sts_pkg::KEY_IN_W-1:0] k);
    sts_pkg::out_item_t res;
    int                 n;
    int                 lo;
    int                 hi;
    int                 mid;
    res = '0;
    n = int'(entries_cfg);
    if (n > TBL_DEPTH) n = TBL_DEPTH;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_mem[mid] == k) begin
        while (mid > 0 && key_mem[mid-1] == k) mid = mid - 1;
        res.found = 1'b1;
        res.first_index = mid[sts_pkg::IDX_W-1:0];
        return res;
      end
      if (k < key_mem[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return res;
  endfunction

  task automatic send_item(sts_pkg::in_item_t item);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (item.mode == sts_pkg::MODE_WRITE) begin
      key_mem[item.entry_index] = item.key;
      writes_sent++;
    end else begin
      lookup_results_q.push_back(predict_lookup(item.key));
      lookups_sent++;
    end
  endtask

  task automatic store_key(int idx, logic [sts_pkg::KEY_IN_W-1:0] k);
    sts_pkg::in_item_t item;
    item.mode        = sts_pkg::MODE_WRITE;
    item.entry_index = idx[sts_pkg::IDX_W-1:0];
    item.key         = k;
    send_item(item);
  endtask

  task automatic lookup_key(logic [sts_pkg::KEY_IN_W-1:0] k);
    sts_pkg::in_item_t item;
    item.mode        = sts_pkg::MODE_LOOKUP;
    item.entry_index = sts_pkg::IDX_W'($urandom_range(0, TBL_DEPTH - 1));
    item.key         = k;
    send_item(item);
  endtask

  task automatic write_reg(logic [sts_pkg::PADDR_W-1:0] addr,
                           logic [sts_pkg::PDATA_W-1:0] data);
    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == sts_pkg::REG_ENTRIES_IN_USE) begin
      entries_cfg = data[sts_pkg::CNT_W-1:0];
      sizes_set++;
      // read back in a second transfer
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== sts_pkg::PDATA_W'(entries_cfg)) begin
        $error("entries_in_use readback: expected %0d, actual %0d", entries_cfg, prdata);
        error_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_empty_table();
    lookup_key('0);
    lookup_key('1);
  endtask

  task automatic test_fill_store();
    for (int i = 0; i < TBL_DEPTH; i++)
      store_key(i, (i == TBL_DEPTH - 1) ? '1 : sts_pkg::KEY_IN_W'(i) * 32'h0040_0000);
  endtask

  task automatic test_full_table_edges();
    write_reg(ADDR_ENTRIES, sts_pkg::PDATA_W'(TBL_DEPTH));
    lookup_key('0);
    lookup_key('1);
    lookup_key(32'h0040_0001);
    lookup_key(32'h7FC0_0000);
    write_reg(ADDR_ENTRIES, 32'd1);
    lookup_key('0);
    lookup_key(32'h0040_0000);
  endtask

  task automatic test_oversized_table();
    write_reg(ADDR_ENTRIES, sts_pkg::PDATA_W'((1 << sts_pkg::CNT_W) - 1));
    lookup_key('1);
    lookup_key(32'h0040_0000);
    write_reg(ADDR_ENTRIES, sts_pkg::PDATA_W'(TBL_DEPTH + 1));
    lookup_key('1);
  endtask

  task automatic test_unmapped_register();
    write_reg(ADDR_UNMAPPED, 32'd3);
    lookup_key('1);
  endtask

  task automatic test_duplicate_run();
    for (int i = 0; i < 4; i++) store_key(i, 32'd5);
    store_key(4, 32'd9);
    store_key(5, 32'd9);
    write_reg(ADDR_ENTRIES, 32'd6);
    lookup_key(32'd5);
    lookup_key(32'd9);
    lookup_key(32'd7);
  endtask

  task automatic test_unsorted_store();
    for (int i = 0; i < 4; i++) store_key(i, sts_pkg::KEY_IN_W'(40 - 10 * i));
    write_reg(ADDR_ENTRIES, 32'd4);
    lookup_key(32'd10);
    lookup_key(32'd30);
  endtask

  task automatic load_sorted_prefix(int m, bit dup_heavy);
    logic [32:0]                  acc;
    logic [sts_pkg::KEY_IN_W-1:0] limit;
    logic [sts_pkg::KEY_IN_W-1:0] span;
    bit                           hold;
    limit = (m < TBL_DEPTH) ? key_mem[m] : '1;
    span  = limit / sts_pkg::KEY_IN_W'(m + 1);
    acc   = 33'($urandom_range(0, span));
    for (int j = 0; j < m; j++) begin
      store_key(j, acc[sts_pkg::KEY_IN_W-1:0]);
      hold = dup_heavy ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 2) == 0);
      if (!hold) acc = acc + 33'($urandom_range(1, span + 1));
      if (acc > 33'(limit)) acc = 33'(limit);
    end
  endtask

  task automatic test_random_phases();
    int                           start;
    int                           r;
    int                           n;
    int                           reach;
    int                           m;
    int                           idx;
    logic [sts_pkg::KEY_IN_W-1:0] k;
    logic [sts_pkg::PDATA_W-1:0]  word;
    start = writes_sent + lookups_sent;
    while (writes_sent + lookups_sent - start < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 24);
      else if (r < 85) n = $urandom_range(25, TBL_DEPTH);
      else if (r < 92) n = 0;
      else if (r < 96) n = TBL_DEPTH;
      else n = $urandom_range(TBL_DEPTH + 1, (1 << sts_pkg::CNT_W) - 1);
      reach = (n > TBL_DEPTH) ? TBL_DEPTH : n;
      m = (reach <= 64) ? reach : $urandom_range(0, 64);
      if ($urandom_range(0, 7) == 0) begin
        for (int j = 0; j < m; j++) store_key(j, $urandom());
      end else begin
        load_sorted_prefix(m, $urandom_range(0, 9) == 0);
      end
      word = sts_pkg::PDATA_W'(n);
      if ($urandom_range(0, 3) == 0)
        word = word | ($urandom() & ~sts_pkg::PDATA_W'((1 << sts_pkg::CNT_W) - 1));
      write_reg(ADDR_ENTRIES, word);
      repeat ($urandom_range(4, 16)) begin
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, TBL_DEPTH - 1);
          store_key(idx, ($urandom_range(0, 1) == 0) ? key_mem[idx] : $urandom());
        end
        r = $urandom_range(0, 99);
        idx = (reach > 0) ? $urandom_range(0, reach - 1) : 0;
        if (r < 60 && reach > 0) k = key_mem[idx];
        else if (r < 75 && reach > 0) k = key_mem[idx] + (($urandom_range(0, 1) == 0) ? 1 : -1);
        else if (r < 85) k = ($urandom_range(0, 1) == 0) ? '0 : '1;
        else k = $urandom();
        lookup_key(k);
      end
    end
    tx_quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
  end

  always @(posedge clk) begin : check_results
    sts_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lookup_results_q.size() == 0) begin
        $error("unexpected result: found %0d, first_index %0d", out_data.found,
               out_data.first_index);
        error_count++;
      end else begin
        want = lookup_results_q.pop_front();
        results_checked++;
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_data.found);
          error_count++;
        end
        if (out_data.first_index !== want.first_index) begin
          $error("first_index: expected %0d, actual %0d", want.first_index,
                 out_data.first_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("sorted_table_first_match_search_top test failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    entries_cfg = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_store();
    test_full_table_edges();
    test_oversized_table();
    test_unmapped_register();
    test_duplicate_run();
    test_unsorted_store();
    test_random_phases();

    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d store writes and %0d lookups across %0d table sizes.",
             writes_sent, lookups_sent, sizes_set);
    $display("Compared %0d lookup results; %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("sorted_table_first_match_search_top test passed");
    end else begin
      $display("sorted_table_first_match_search_top test failed");
    end
    $finish;
  end

endmodule
